>>> hw/rtl/lrukv_pkg.sv
package lrukv_pkg;

   localparam int ENTRIES   = 16;
   localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int CAP_W     = 5;
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KEY_W     = 32;
   localparam int VALUE_W   = 32;
   localparam int REQ_DATA_W = KEY_W + VALUE_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [CNT_W-1:0]   count_type;

endpackage

>>> hw/rtl/lru_key_value_cache_core.sv
// channel | direction | tdata (low bit up)                  | tuser
// --------+-----------+-------------------------------------+--------------
// req     | in        | lookup_key [31:0], write_value[63:32] | mode (0 get, 1 put)
// rsp     | out       | read_value [31:0]                    | hit
// csr     | in        | capacity [4:0] (csr_data)            | -
//
// One word per cycle enters the input register while req_tready is high; from there
// it is looked up against all 16 entries, keys, values and ranks are updated, and a
// get loads the result register, which drives rsp_tvalid.
// A put never waits on rsp; a get stalls in the input register while a result
// is held and rsp_tready is low.
// Synchronous reset empties the cache (fill count zero) and sets capacity to 16.
module lru_key_value_cache_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lrukv_pkg::REQ_DATA_W-1:0]   req_tdata,  // lookup_key, write_value
   input  logic                               req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lrukv_pkg::VALUE_W-1:0]      rsp_tdata,  // read_value
   output logic                               rsp_tuser,  // hit
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lrukv_pkg::CAP_W-1:0]        csr_data    // capacity
);
   import lrukv_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic                   in_mode_ff, in_mode_in;
   key_type                in_key_ff, in_key_in;
   value_type              in_value_ff, in_value_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   value_type              rsp_value_ff, rsp_value_in;

   count_type              fill_ff, fill_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;

   key_type                key_ff [ENTRIES];
   key_type                key_in [ENTRIES];
   value_type              val_ff [ENTRIES];
   value_type              val_in [ENTRIES];
   slot_type               rank_ff [ENTRIES];
   slot_type               rank_in [ENTRIES];

   logic [ENTRIES-1:0]     live;
   logic [ENTRIES-1:0]     match;
   logic [ENTRIES-1:0]     victim;
   logic                   hit;
   slot_type               hit_slot;
   slot_type               hit_rank;
   value_type              hit_value;
   slot_type               victim_slot;
   count_type              oldest_rank;
   logic [CMP_W-1:0]       eff_cap;
   logic                   room;
   logic                   proc;
   logic                   is_put;
   logic                   touch;
   slot_type               target_slot;
   count_type              target_rank;
   logic                   accept;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

   assign is_put     = (in_mode_ff == MODE_PUT);
   assign proc       = in_valid_ff && (is_put || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc;
   assign accept     = req_tvalid && req_tready;
   assign oldest_rank = fill_ff - count_type'(1);

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign room = CMP_W'(fill_ff) < eff_cap;

   always_comb begin
      hit_slot    = '0;
      hit_rank    = '0;
      hit_value   = '0;
      victim_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         live[i]   = CNT_W'(i) < fill_ff;
         match[i]  = live[i] && (key_ff[i] == in_key_ff);
         victim[i] = live[i] && (CNT_W'(rank_ff[i]) == oldest_rank);
         hit_slot    = hit_slot    | (match[i]  ? SLOT_W'(i) : '0);
         hit_rank    = hit_rank    | (match[i]  ? rank_ff[i] : '0);
         hit_value   = hit_value   | (match[i]  ? val_ff[i]  : '0);
         victim_slot = victim_slot | (victim[i] ? SLOT_W'(i) : '0);
      end
      hit = |match;
   end

   always_comb begin
      if (hit) begin
         target_slot = hit_slot;
         target_rank = CNT_W'(hit_rank);
      end else if (room) begin
         target_slot = fill_ff[SLOT_W-1:0];
         target_rank = fill_ff;
      end else begin
         target_slot = victim_slot;
         target_rank = oldest_rank;
      end
   end

   assign touch = proc && (hit || is_put);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]  = key_ff[i];
         val_in[i]  = val_ff[i];
         rank_in[i] = rank_ff[i];
         if (touch) begin
            if (SLOT_W'(i) == target_slot) begin
               rank_in[i] = '0;
               if (is_put) begin
                  key_in[i] = in_key_ff;
                  val_in[i] = in_value_ff;
               end
            end else if (live[i] && (CNT_W'(rank_ff[i]) < target_rank)) begin
               rank_in[i] = rank_ff[i] + slot_type'(1);
            end
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (proc && is_put && !hit && room) begin
         fill_in = fill_ff + count_type'(1);
      end
      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_mode_in  = in_mode_ff;
      in_key_in   = in_key_ff;
      in_value_in = in_value_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_mode_in  = req_tuser;
         in_key_in   = req_tdata[KEY_W-1:0];
         in_value_in = req_tdata[KEY_W +: VALUE_W];
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      if (proc && !is_put) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
         rsp_value_in = hit ? hit_value : MISS_VALUE;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      in_mode_ff   <= in_mode_in;
      in_key_ff    <= in_key_in;
      in_value_ff  <= in_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]  <= key_in[i];
         val_ff[i]  <= val_in[i];
         rank_ff[i] <= rank_in[i];
      end
   end

endmodule
